### hw/rtl/aks_pkg.sv
package aks_pkg;

   localparam int COLUMNS = 4;
   localparam int WINDOW_DEPTH = 8;

   // key_length_mode codes
   localparam logic [1:0] MODE_128 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;
   localparam logic [1:0] MODE_256 = 2'd2;

   localparam logic [3:0] NK_128 = 4'd4;
   localparam logic [3:0] NK_192 = 4'd6;
   localparam logic [3:0] NK_256 = 4'd8;

   // last schedule word index per key size: COLUMNS * (Nr + 1) - 1
   localparam logic [5:0] LAST_IDX_128 = 6'(COLUMNS * 11 - 1);
   localparam logic [5:0] LAST_IDX_192 = 6'(COLUMNS * 13 - 1);
   localparam logic [5:0] LAST_IDX_256 = 6'(COLUMNS * 15 - 1);

   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY = 8'h1b;

   // group offset of the substitute-only word in 256-bit keys
   localparam logic [2:0] SUB_ONLY_OFFSET = 3'd4;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   typedef struct packed {
      logic       rot_sub;   // group start: rotate, substitute, add round constant
      logic       sub_only;  // 256-bit middle word: substitute only
      logic [7:0] rcon;
   } step_ctl_type;

   function automatic logic [31:0] sbox_word(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

endpackage

### hw/rtl/aes_key_schedule_core.sv
// Each key word is echoed on rsp in the cycle after it is taken.
// After the final key word, the remaining 40, 46 or 52 schedule words follow at
// one word per cycle while rsp_ready is high; req_ready stays low until the last one.
// One word per cycle is set by the single shared S-box/XOR word unit.
// Reset clears the sequencer, output valid and key load count; the key size returns to 128-bit.
module aes_key_schedule_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_key_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_word_index,
   output logic [31:0] rsp_round_word,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_write_data
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_EXPAND = 1'b1;

   logic        state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [2:0]  seen_ff, seen_in;
   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  off_ff, off_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_idx_ff, rsp_idx_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] win_ff [aks_pkg::WINDOW_DEPTH];
   logic [31:0] win_in [aks_pkg::WINDOW_DEPTH];

   logic [3:0]  nk;
   logic [2:0]  nk_m1;
   logic [5:0]  last_idx;
   logic [31:0] back_word;
   logic [2:0]  pos;
   logic        out_free;
   logic        shift_en;
   logic [31:0] shift_word;

   aks_pkg::step_ctl_type ctl;
   logic [31:0] new_word;
   logic [7:0]  next_rcon;

   always_comb begin
      case (mode_ff)
         aks_pkg::MODE_192: begin
            nk        = aks_pkg::NK_192;
            last_idx  = aks_pkg::LAST_IDX_192;
            back_word = win_ff[5];
         end
         aks_pkg::MODE_256: begin
            nk        = aks_pkg::NK_256;
            last_idx  = aks_pkg::LAST_IDX_256;
            back_word = win_ff[7];
         end
         default: begin
            nk        = aks_pkg::NK_128;
            last_idx  = aks_pkg::LAST_IDX_128;
            back_word = win_ff[3];
         end
      endcase
   end

   assign nk_m1 = 3'(nk - 4'd1);
   assign pos   = ({1'b0, seen_ff} >= nk) ? nk_m1 : seen_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   assign ctl.rot_sub  = (off_ff == 3'd0);
   assign ctl.sub_only = (mode_ff == aks_pkg::MODE_256) && (off_ff == aks_pkg::SUB_ONLY_OFFSET);
   assign ctl.rcon     = rcon_ff;

   aks_word_unit u_word (
      .prev_word (win_ff[0]),
      .back_word (back_word),
      .ctl       (ctl),
      .new_word  (new_word),
      .next_rcon (next_rcon)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      rcon_in      = rcon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      shift_en     = 1'b0;
      shift_word   = req_key_word;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               shift_en     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = {3'b000, pos};
               rsp_word_in  = req_key_word;
               rsp_last_in  = 1'b0;
               if (pos == nk_m1) begin
                  state_in = ST_EXPAND;
                  idx_in   = {2'b00, nk};
                  off_in   = 3'd0;
                  rcon_in  = aks_pkg::RCON_INIT;
               end else begin
                  seen_in = pos + 3'd1;
               end
            end
         end
         ST_EXPAND: begin
            if (out_free) begin
               shift_en     = 1'b1;
               shift_word   = new_word;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               rsp_word_in  = new_word;
               rsp_last_in  = (idx_ff == last_idx);
               if (idx_ff == last_idx) begin
                  state_in = ST_IDLE;
                  seen_in  = 3'd0;
               end else begin
                  idx_in  = idx_ff + 6'd1;
                  off_in  = (off_ff == nk_m1) ? 3'd0 : off_ff + 3'd1;
                  rcon_in = ctl.rot_sub ? next_rcon : rcon_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // user must send writes only while idle (unenforced); a write restarts the key load
      if (csr_write_en) begin
         mode_in = csr_write_data;
         seen_in = 3'd0;
      end
   end

   // newest word at tap 0, word i-Nk at tap Nk-1
   always_comb begin
      for (int k = 0; k < aks_pkg::WINDOW_DEPTH; k++) begin
         win_in[k] = win_ff[k];
      end
      if (shift_en) begin
         win_in[0] = shift_word;
         for (int k = 1; k < aks_pkg::WINDOW_DEPTH; k++) begin
            win_in[k] = win_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= aks_pkg::MODE_128;
         seen_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      off_ff      <= off_in;
      rcon_ff     <= rcon_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      for (int k = 0; k < aks_pkg::WINDOW_DEPTH; k++) begin
         win_ff[k] <= win_in[k];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_index = rsp_idx_ff;
   assign rsp_round_word = rsp_word_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### hw/rtl/aks_word_unit.sv
module aks_word_unit (
   input  logic [31:0]            prev_word,
   input  logic [31:0]            back_word,
   input  aks_pkg::step_ctl_type  ctl,
   output logic [31:0]            new_word,
   output logic [7:0]             next_rcon
);

   logic [31:0] sub_in;
   logic [31:0] sub_out;
   logic [31:0] temp;

   // one S-box word, shared by the rotate and substitute-only cases
   assign sub_in  = ctl.rot_sub ? {prev_word[23:0], prev_word[31:24]} : prev_word;
   assign sub_out = aks_pkg::sbox_word(sub_in);

   always_comb begin
      if (ctl.rot_sub) begin
         temp = sub_out ^ {ctl.rcon, 24'h000000};
      end else if (ctl.sub_only) begin
         temp = sub_out;
      end else begin
         temp = prev_word;
      end
   end

   assign new_word  = back_word ^ temp;
   assign next_rcon = {ctl.rcon[6:0], 1'b0} ^ (ctl.rcon[7] ? aks_pkg::GF_POLY : 8'h00);

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_RSVD = 2'd3;  // decodes as a 128-bit key
   localparam int TOTAL_WORDS = 210;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [5:0]  idx;
      logic [31:0] word;
      logic        fin;
   } sched_word_type;

   class key_schedule_board;
      logic [31:0]    window [aks_pkg::WINDOW_DEPTH];
      int             words_seen;
      logic [7:0]     rcon_next;
      logic [1:0]     mode;
      sched_word_type pending_words [$];
      int             errors;
      int             keys_taken;
      int             words_checked;
      int             sched_done [4];

      function new();
         foreach (window[i]) window[i] = '0;
         words_seen = 0;
         rcon_next = aks_pkg::RCON_INIT;
         mode = aks_pkg::MODE_128;
      endfunction

      function void write_mode(logic [1:0] m);
         mode = m;
         words_seen = 0;
         rcon_next = aks_pkg::RCON_INIT;
      endfunction

      function int pending_count();
         return pending_words.size();
      endfunction

      function logic [31:0] sbox_lookup(logic [31:0] v);
         logic [31:0] r;
         for (int b = 0; b < 4; b++) r[8*b +: 8] = aks_pkg::SBOX[v[8*b +: 8]];
         return r;
      endfunction

      // one key word in; its echo and, on the final key word, the rest of the schedule
      function void note_key_word(logic [31:0] kw);
         int nk, total, pos;
         logic [31:0] t, w;
         nk = (mode == aks_pkg::MODE_192) ? aks_pkg::NK_192 :
              (mode == aks_pkg::MODE_256) ? aks_pkg::NK_256 : aks_pkg::NK_128;
         total = aks_pkg::COLUMNS * (nk + 7);
         keys_taken++;
         pos = words_seen & 7;
         if (pos >= nk) pos = nk - 1;
         window[pos] = kw;
         pending_words.push_back('{idx: 6'(pos), word: kw, fin: 1'b0});
         if (pos < nk - 1) begin
            words_seen = pos + 1;
            return;
         end
         rcon_next = aks_pkg::RCON_INIT;
         for (int i = nk; i < total; i++) begin
            t = window[(i - 1) & 7];
            if (i % nk == 0) begin
               t = sbox_lookup({t[23:0], t[31:24]}) ^ {rcon_next, 24'h0};
               rcon_next = {rcon_next[6:0], 1'b0} ^
                           (rcon_next[7] ? aks_pkg::GF_POLY : 8'h00);
            end else if (nk > 6 && i % nk == aks_pkg::SUB_ONLY_OFFSET) begin
               t = sbox_lookup(t);
            end
            w = window[(i - nk) & 7] ^ t;
            window[i & 7] = w;
            pending_words.push_back('{idx: 6'(i), word: w, fin: (i + 1 == total)});
         end
         words_seen = 0;
         rcon_next = aks_pkg::RCON_INIT;
         sched_done[mode]++;
      endfunction

      function void check_round_word(logic [5:0] idx, logic [31:0] word, logic fin);
         sched_word_type exp_w;
         if (pending_words.size() == 0) begin
            $error("unexpected word: index %0d value %08h last %0b", idx, word, fin);
            errors++;
            return;
         end
         exp_w = pending_words.pop_front();
         words_checked++;
         if (idx !== exp_w.idx) begin
            $error("word_index mismatch: expected %0d, actual %0d", exp_w.idx, idx);
            errors++;
         end
         if (word !== exp_w.word) begin
            $error("round_word mismatch: expected %08h, actual %08h", exp_w.word, word);
            errors++;
         end
         if (fin !== exp_w.fin) begin
            $error("last mismatch: expected %0b, actual %0b", exp_w.fin, fin);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_key_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_word_index;
   logic [31:0] rsp_round_word;
   logic        rsp_last;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_write_data = '0;

   key_schedule_board sb = new();
   bit hold_req = 1'b0;
   bit calm = 1'b0;
   int sent = 0;

   aes_key_schedule_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_word   (req_key_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_round_word (rsp_round_word),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_key_word(req_key_word);
         if (rsp_valid && rsp_ready) sb.check_round_word(rsp_word_index, rsp_round_word, rsp_last);
      end
   end

   // receiver: short stall bursts, one long hold-off on request, none at the end
   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [31:0] kw);
      req_valid <= 1'b1;
      req_key_word <= kw;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // stop offering words until every expected word has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   task automatic write_mode(logic [1:0] m);
      settle();
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= m;
      sb.write_mode(m);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_key_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] fips128 [4];
      logic [31:0] fips256 [8];
      logic [1:0] m;
      int nk, nwords;
      bit first, broken;

      fips128 = '{32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c};
      fips256 = '{32'h603deb10, 32'h15ca71be, 32'h2b73aef0, 32'h857d7781,
                  32'h1f352c07, 32'h3b6108d7, 32'h2d9810a3, 32'h0914dff4};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset-default 128-bit key, reserved mode with all-ones key,
      // a key load cut short by a mode write, all-zero 192-bit key, 256-bit key
      foreach (fips128[i]) send_word(fips128[i]);
      write_mode(MODE_RSVD);
      repeat (4) send_word(32'hffff_ffff);
      write_mode(aks_pkg::MODE_256);
      send_word(32'h8000_0001);
      send_word(32'h7fff_fffe);
      write_mode(aks_pkg::MODE_192);
      repeat (6) send_word(32'h0000_0000);
      write_mode(aks_pkg::MODE_256);
      foreach (fips256[i]) send_word(fips256[i]);

      first = 1'b1;
      while (sent < TOTAL_WORDS) begin
         if (sent >= TOTAL_WORDS - 25) calm = 1'b1;
         m = first ? aks_pkg::MODE_256 : 2'($urandom_range(0, 3));
         write_mode(m);
         nk = (m == aks_pkg::MODE_192) ? aks_pkg::NK_192 :
              (m == aks_pkg::MODE_256) ? aks_pkg::NK_256 : aks_pkg::NK_128;
         for (int k = $urandom_range(1, 3); k > 0; k--) begin
            broken = !first && $urandom_range(0, 7) == 0;
            nwords = broken ? $urandom_range(1, nk - 1) : nk;
            if (first) hold_req = 1'b1;  // block fills and stalls the input
            for (int w = 0; w < nwords; w++) begin
               send_word(rand_key_word());
               if (!calm && $urandom_range(0, 24) == 0) settle();
            end
            first = 1'b0;
            if (broken) break;
         end
      end

      settle();
      repeat (20) @(posedge clock);
      $display("Covered %0d key words and %0d checked schedule words, incl. a long output stall",
               sb.keys_taken, sb.words_checked);
      $display("Full schedules for 128/192/256-bit keys and reserved mode: %0d/%0d/%0d/%0d",
               sb.sched_done[aks_pkg::MODE_128], sb.sched_done[aks_pkg::MODE_192],
               sb.sched_done[aks_pkg::MODE_256], sb.sched_done[MODE_RSVD]);
      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
